/* hdl/pip_pkg.sv */
// Shared types and constants for the point-in-polygon test block.
// No dependencies; imported by the top level and the multiplier unit.
package pip_pkg;

	localparam int LAT_W     = 28;           // vertex and query latitude
	localparam int LNG_W     = 29;           // vertex and query longitude
	localparam int DLAT_W    = LAT_W + 1;    // latitude difference
	localparam int OPND_W    = LNG_W + 1;    // multiplier operand, longitude difference
	localparam int PROD_W    = 2 * OPND_W;   // multiplier product
	localparam int DEV_W     = PROD_W + 1;   // difference of two products
	localparam int VTX_W     = LAT_W + LNG_W;
	localparam int REQ_W     = 2;
	localparam int S_DATA_W  = 64;
	localparam int M_DATA_W  = 8;
	localparam int MIN_VERTICES = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_QUERY  = 2'd2
	} req_t;

endpackage

/* hdl/pip_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the polygon vertices.
module pip_ram #(
	parameter int WIDTH = 57,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/pip_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on pip_pkg for operand and product widths.
module pip_mul
	import pip_pkg::*;
(
	input  logic                     clk,
	input  logic signed [OPND_W-1:0] op_a,
	input  logic signed [OPND_W-1:0] op_b,
	output logic signed [PROD_W-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule

/* hdl/point_in_polygon_test.sv */
// Point-in-polygon test top level: request stream in, one result per defined request out.
// Depends on pip_pkg, pip_ram (vertex store) and pip_mul (shared multiplier).
//
// The block keeps a polygon of up to MAX_VERTICES vertices in micro-degrees and
// answers ray-crossing queries against it. Each input transfer carries a request
// kind on s_axis_tuser: clear (one result, all flags zero), append a vertex (one
// result, rejected set when the store is already full) or query a point (one
// result with inside_res and on_edge). The unused request code is taken and
// dropped without a result. Clear and append finish in the cycle they are taken.
// A query with N >= 3 stored vertices goes through a start, a fetch of the first
// vertex from the store, states E1 and E2 for each edge, and a state that settles
// the last edge. The two states per edge are set by the single multiplier, which
// forms both cross products of the edge test one after the other; the store's
// single read port delivers the next vertex in step with it. A query with fewer
// than three vertices answers outside when taken. The block takes no new
// request while a query walks the polygon. A finished result waits in an output
// register, and a new request is taken as soon as that register is free or being
// emptied. The vertex store needs no clearing after reset; only entries below
// the vertex count are ever used.
module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// request stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // point_lat [27:0], point_lng [56:28], zero pad
	input  logic [REQ_W-1:0]    s_axis_tuser,  // req_type [1:0]
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata   // inside_res [0], on_edge [1], rejected [2], zero pad
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = $clog2(MAX_VERTICES);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_E1   = 5'b00100,
		ST_E2   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t st_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] edge_q;

	// query point, current edge endpoints, first vertex
	logic signed [LAT_W-1:0] qlat_q, alat_q, blat_q, flat_q;
	logic signed [LNG_W-1:0] qlng_q, alng_q, blng_q, flng_q;

	// edge accumulation
	logic                     cross_q;
	logic                     hit_q;
	logic                     pend_q;
	logic                     below_q;
	logic signed [DLAT_W-1:0] d_q;
	logic signed [PROD_W-1:0] prod1_q;

	// output register
	logic m_valid_q, inside_q, on_edge_q, rejected_q;

	logic accept;
	logic res_load;
	req_t req;
	logic signed [LAT_W-1:0] in_lat;
	logic signed [LNG_W-1:0] in_lng;

	assign s_axis_tready = (st_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign req    = req_t'(s_axis_tuser);
	assign in_lat = s_axis_tdata[LAT_W-1:0];
	assign in_lng = s_axis_tdata[VTX_W-1:LAT_W];

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(M_DATA_W-3)'(0), rejected_q, on_edge_q, inside_q};

	// ------------------------------------------------------------------
	// Vertex store
	// ------------------------------------------------------------------
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [VTX_W-1:0] ram_rdata;
	logic [CNT_W-1:0] nxt_rd;
	logic             last_edge;
	logic             full;

	assign full      = (cnt_q == CNT_W'(MAX_VERTICES));
	assign last_edge = ((CNT_W'(edge_q) + CNT_W'(1)) == cnt_q);
	assign nxt_rd    = CNT_W'(edge_q) + CNT_W'(2);
	assign ram_we    = accept && (req == REQ_APPEND) && !full;

	// a result enters the output register this cycle
	assign res_load = (st_q == ST_FIN) ||
		((st_q == ST_IDLE) && accept && ((req == REQ_CLEAR) || (req == REQ_APPEND) ||
		((req == REQ_QUERY) && (cnt_q < CNT_W'(MIN_VERTICES)))));

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (st_q)
			ST_IDLE: begin
				ram_re = accept && (req == REQ_QUERY);
			end
			ST_LOAD: begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(1);
			end
			ST_E2: begin
				ram_re    = (nxt_rd < cnt_q);
				ram_raddr = nxt_rd[IDX_W-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	pip_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_VERTICES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(s_axis_tdata[VTX_W-1:0]),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------------
	// Edge arithmetic around the shared multiplier
	// ------------------------------------------------------------------
	logic signed [LAT_W-1:0]  b_lat, lo_lat, hi_lat;
	logic signed [LNG_W-1:0]  b_lng, lo_lng, hi_lng;
	logic signed [DLAT_W-1:0] d_lat, dq_lat;
	logic signed [OPND_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] mul_p;
	logic out_lat, east, west, flat;
	logic west_cross, flat_hit, gen_edge;

	// the closing edge runs back to the first vertex
	assign b_lat = last_edge ? flat_q : ram_rdata[LAT_W-1:0];
	assign b_lng = last_edge ? flng_q : ram_rdata[VTX_W-1:LAT_W];

	assign lo_lat = (alat_q < b_lat) ? alat_q : b_lat;
	assign hi_lat = (alat_q < b_lat) ? b_lat : alat_q;
	assign lo_lng = (alng_q < b_lng) ? alng_q : b_lng;
	assign hi_lng = (alng_q < b_lng) ? b_lng : alng_q;
	assign d_lat  = {alat_q[LAT_W-1], alat_q} - {b_lat[LAT_W-1], b_lat};
	assign dq_lat = {qlat_q[LAT_W-1], qlat_q} - {alat_q[LAT_W-1], alat_q};

	assign out_lat = (qlat_q < lo_lat) || (qlat_q > hi_lat);
	assign east    = (qlng_q > hi_lng);
	assign west    = (qlng_q < lo_lng);
	assign flat    = (alat_q == b_lat) || (alng_q == b_lng);

	assign west_cross = !out_lat && !east && west && (qlat_q < hi_lat);
	assign flat_hit   = !out_lat && !east && !west && flat;
	assign gen_edge   = !out_lat && !east && !west && !flat;

	// first product in E1 from the live edge, second in E2 from the held edge
	always_comb begin
		if (st_q == ST_E2) begin
			op_a = OPND_W'(dq_lat);
			op_b = {alng_q[LNG_W-1], alng_q} - {blng_q[LNG_W-1], blng_q};
		end else begin
			op_a = {qlng_q[LNG_W-1], qlng_q} - {alng_q[LNG_W-1], alng_q};
			op_b = OPND_W'(d_lat);
		end
	end

	pip_mul u_mul (
		.clk (clk),
		.op_a(op_a),
		.op_b(op_b),
		.prod(mul_p)
	);

	// settle a pending general edge: mul_p holds its second product here
	logic signed [DEV_W-1:0]  dev;
	logic        [DEV_W-1:0]  abs_dev;
	logic        [DLAT_W-1:0] abs_d;
	logic                     res_hit, res_cross;

	assign dev       = {prod1_q[PROD_W-1], prod1_q} - {mul_p[PROD_W-1], mul_p};
	assign abs_dev   = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
	assign abs_d     = d_q[DLAT_W-1] ? DLAT_W'(-d_q) : DLAT_W'(d_q);
	assign res_hit   = pend_q && (abs_dev < DEV_W'(abs_d));
	assign res_cross = pend_q && !res_hit && (dev[DEV_W-1] ^ d_q[DLAT_W-1]) && below_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			// hold a fresh result; drop the old one once it is taken
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						inside_q   <= 1'b0;
						on_edge_q  <= 1'b0;
						rejected_q <= 1'b0;
						case (req)
							REQ_CLEAR: begin
								cnt_q <= '0;
							end
							REQ_APPEND: begin
								if (full) begin
									rejected_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							REQ_QUERY: begin
								qlat_q <= in_lat;
								qlng_q <= in_lng;
								if (cnt_q >= CNT_W'(MIN_VERTICES)) begin
									st_q <= ST_LOAD;
								end
							end
							default: begin
								// drop the undefined code
							end
						endcase
					end
				end
				ST_LOAD: begin
					// hold the first vertex for the closing edge
					alat_q  <= ram_rdata[LAT_W-1:0];
					alng_q  <= ram_rdata[VTX_W-1:LAT_W];
					flat_q  <= ram_rdata[LAT_W-1:0];
					flng_q  <= ram_rdata[VTX_W-1:LAT_W];
					edge_q  <= '0;
					cross_q <= 1'b0;
					hit_q   <= 1'b0;
					pend_q  <= 1'b0;
					st_q    <= ST_E1;
				end
				ST_E1: begin
					blat_q  <= b_lat;
					blng_q  <= b_lng;
					d_q     <= d_lat;
					below_q <= (qlat_q < hi_lat);
					pend_q  <= gen_edge;
					cross_q <= cross_q ^ west_cross ^ res_cross;
					hit_q   <= hit_q | flat_hit | res_hit;
					st_q    <= ST_E2;
				end
				ST_E2: begin
					// advance to the next edge
					prod1_q <= mul_p;
					alat_q  <= blat_q;
					alng_q  <= blng_q;
					edge_q  <= edge_q + IDX_W'(1);
					st_q    <= last_edge ? ST_FIN : ST_E1;
				end
				ST_FIN: begin
					inside_q  <= (hit_q | res_hit) | (cross_q ^ res_cross);
					on_edge_q <= hit_q | res_hit;
					pend_q    <= 1'b0;
					st_q      <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	a_edge_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
		else $error("on-edge answer without inside");

	a_small_poly: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_QUERY && cnt_q < CNT_W'(MIN_VERTICES))
		|=> (m_axis_tvalid && m_axis_tdata[1:0] == 2'b00))
		else $error("degenerate polygon query must answer outside at once");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_APPEND) |=> (m_axis_tvalid && m_axis_tdata[2] == $past(full)))
		else $error("append reject flag does not match store fill");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_E1) |=> (st_q == ST_E2 && !m_axis_tvalid || st_q == ST_E2 && $stable(m_axis_tdata)))
		else $error("edge walk left its second step");

endmodule

/* dv/point_in_polygon_test_test.sv */
// Self-checking testbench for point_in_polygon_test: drives request transfers, predicts each
// answer from a model of the vertex store kept in a scoreboard class, and checks every result.
// Depends on pip_pkg and the RTL of point_in_polygon_test; reads no files.
module point_in_polygon_test_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pip_pkg::*;

	localparam int STORE_DEPTH    = 64;                  // vertex store size of the instance
	localparam int ITEM_GOAL      = 1500;                // stop offering requests past this count
	localparam int HOLD_CYCLES    = 400;                 // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 5000;                // cycles without any transfer
	localparam int TAIL_CYCLES    = 2 * STORE_DEPTH + 16; // longer than the slowest query

	// request code the block must swallow without an answer
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam longint LAT_HI = (longint'(1) <<< (LAT_W - 1)) - 1;
	localparam longint LAT_LO = -(longint'(1) <<< (LAT_W - 1));
	localparam longint LNG_HI = (longint'(1) <<< (LNG_W - 1)) - 1;
	localparam longint LNG_LO = -(longint'(1) <<< (LNG_W - 1));

	// one expected answer, fields in result order from the highest bit down
	typedef struct packed {
		logic rejected;
		logic on_edge;
		logic inside_res;
	} answer_t;

	// Keeps a private copy of the polygon, predicts the answer of every accepted
	// request and compares the answers coming out of the block in order.
	class pip_scoreboard;
		logic signed [LAT_W-1:0] vtx_lat [STORE_DEPTH];
		logic signed [LNG_W-1:0] vtx_lng [STORE_DEPTH];
		int unsigned vtx_count;
		answer_t     pending_answers [$];
		int          n_queries, n_inside, n_on_edge, n_appends, n_rejected, n_clears, n_ignored;
		int          n_checked, mismatches, strays, reports;

		function new();
			vtx_count = 0;
		endfunction

		// Ray-crossing walk over every edge, closing edge included.
		function void locate_point(input longint qlat, input longint qlng,
				output bit in_poly, output bit on_line);
			int unsigned crossings;
			int unsigned j;
			longint alat, alng, blat, blng, lolat, hilat, lolng, hilng;
			longint dlat, dlng, dev, mag_dev, mag_dlat;
			in_poly = 1'b0;
			on_line = 1'b0;
			crossings = 0;
			if (vtx_count < MIN_VERTICES)
				return;
			for (int unsigned i = 0; i < vtx_count; i++) begin
				j = (i + 1 < vtx_count) ? i + 1 : 0;
				alat = vtx_lat[i];
				alng = vtx_lng[i];
				blat = vtx_lat[j];
				blng = vtx_lng[j];
				lolat = (alat < blat) ? alat : blat;
				hilat = (alat > blat) ? alat : blat;
				lolng = (alng < blng) ? alng : blng;
				hilng = (alng > blng) ? alng : blng;
				// skip edges the ray cannot meet; latitudes count half-open
				if (qlat < lolat || qlat > hilat)
					continue;
				if (qlng > hilng)
					continue;
				if (qlng < lolng) begin
					if (qlat < hilat)
						crossings++;
					continue;
				end
				dlat = alat - blat;
				dlng = alng - blng;
				// inside the box of a flat or vertical edge means on it
				if (dlat == 0 || dlng == 0) begin
					in_poly = 1'b1;
					on_line = 1'b1;
					return;
				end
				// exact cross product replaces the interpolated crossing longitude
				dev = (qlng - alng) * dlat - (qlat - alat) * dlng;
				mag_dev = (dev < 0) ? -dev : dev;
				mag_dlat = (dlat < 0) ? -dlat : dlat;
				if (mag_dev < mag_dlat) begin
					in_poly = 1'b1;
					on_line = 1'b1;
					return;
				end
				if (((dev < 0) != (dlat < 0)) && qlat < hilat)
					crossings++;
			end
			in_poly = crossings[0];
		endfunction

		function void note_request(input logic [REQ_W-1:0] kind, input logic [S_DATA_W-1:0] word);
			answer_t ans;
			bit      in_poly, on_line;
			logic signed [LAT_W-1:0] lat;
			logic signed [LNG_W-1:0] lng;
			ans = '0;
			lat = word[LAT_W-1:0];
			lng = word[VTX_W-1:LAT_W];
			case (kind)
				REQ_CLEAR: begin
					vtx_count = 0;
					n_clears++;
					pending_answers.push_back(ans);
				end
				REQ_APPEND: begin
					n_appends++;
					if (vtx_count >= STORE_DEPTH) begin
						ans.rejected = 1'b1;
						n_rejected++;
					end else begin
						vtx_lat[vtx_count] = lat;
						vtx_lng[vtx_count] = lng;
						vtx_count++;
					end
					pending_answers.push_back(ans);
				end
				REQ_QUERY: begin
					locate_point(lat, lng, in_poly, on_line);
					ans.inside_res = in_poly;
					ans.on_edge = on_line;
					n_queries++;
					n_inside += in_poly;
					n_on_edge += on_line;
					pending_answers.push_back(ans);
				end
				default: begin
					n_ignored++;
				end
			endcase
		endfunction

		function void check_answer(input logic [M_DATA_W-1:0] word);
			answer_t want;
			n_checked++;
			if (pending_answers.size() == 0) begin
				strays++;
				if (reports < 10)
					$display("[%0t] result %0d arrived with no request waiting: data %b",
						$time, n_checked, word);
				reports++;
				return;
			end
			want = pending_answers.pop_front();
			if (word[0] !== want.inside_res || word[1] !== want.on_edge ||
					word[2] !== want.rejected || word[M_DATA_W-1:3] !== '0) begin
				mismatches++;
				if (reports < 10)
					$display({"[%0t] result %0d mismatch: expected inside_res %b on_edge %b ",
						"rejected %b pad 0, got inside_res %b on_edge %b rejected %b pad %b"},
						$time, n_checked, want.inside_res, want.on_edge, want.rejected,
						word[0], word[1], word[2], word[M_DATA_W-1:3]);
				reports++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [REQ_W-1:0]    s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;

	pip_scoreboard board;
	int            sent_items = 0;
	int            quiet_cycles = 0;
	bit            calm = 1'b0;          // no idling on either side while set
	bit            hold_output = 1'b0;   // ask the receiver for one long hold-off
	longint        shape_lat [$];        // vertices sent since the last clear,
	longint        shape_lng [$];        // used to aim queries at edges and corners

	point_in_polygon_test #(
		.MAX_VERTICES(STORE_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // point_lat [27:0], point_lng [56:28], zero pad
		.s_axis_tuser  (s_axis_tuser),   // req_type [1:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // inside_res [0], on_edge [1], rejected [2], zero pad
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Record each accepted request before checking the answer side; an answer
	// never leaves in the same cycle its request was taken, so order is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_request(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				board.check_answer(m_axis_tdata);
		end
	end

	// Stop a hung run: count cycles in which neither side moves a transfer.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: stall with a chance of about 14 in 100, never while calm, and once
	// hold off for a long stretch so the output fills and the input backs up.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	function automatic longint wrap_lat(input longint v);
		logic signed [LAT_W-1:0] t;
		t = v[LAT_W-1:0];
		return t;
	endfunction

	function automatic longint wrap_lng(input longint v);
		logic signed [LNG_W-1:0] t;
		t = v[LNG_W-1:0];
		return t;
	endfunction

	// Offer one request and hold it until the block takes it. Random idle
	// cycles go in front; valid stays high across back-to-back transfers.
	task automatic send_request(input logic [REQ_W-1:0] kind, input longint lat,
			input longint lng);
		logic [S_DATA_W-1:0] word;
		word = '0;
		word[LAT_W-1:0] = lat[LAT_W-1:0];
		word[VTX_W-1:LAT_W] = lng[LNG_W-1:0];
		while (!calm && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (kind != REQ_UNUSED)
			sent_items++;
	endtask

	// Drop valid and wait until every answer owed has come back.
	task automatic wait_for_answers();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Small hand-picked polygons: empty and two-vertex stores, a right triangle
	// with flat, vertical and slanted edges, and a triangle at the field limits.
	task automatic run_directed();
		send_request(REQ_QUERY, 0, 0);
		send_request(REQ_APPEND, 0, 0);
		send_request(REQ_APPEND, 0, 100);
		send_request(REQ_QUERY, 0, 50);        // on the segment, still too few vertices
		send_request(REQ_APPEND, 100, 0);
		send_request(REQ_QUERY, 10, 10);
		send_request(REQ_QUERY, 200, 200);
		send_request(REQ_QUERY, 0, 50);        // flat edge
		send_request(REQ_QUERY, 50, 0);        // vertical edge
		send_request(REQ_QUERY, 50, 50);       // slanted edge, exact
		send_request(REQ_QUERY, 50, 51);       // just past the slanted edge
		send_request(REQ_QUERY, 0, 0);         // corner
		send_request(REQ_QUERY, -1, 10);       // just below the lower latitude
		send_request(REQ_UNUSED, LAT_HI, LNG_LO);
		send_request(REQ_CLEAR, LAT_LO, LNG_HI);
		send_request(REQ_QUERY, 10, 10);
		send_request(REQ_APPEND, LAT_LO, LNG_LO);
		send_request(REQ_APPEND, LAT_HI, LNG_HI);
		send_request(REQ_APPEND, LAT_HI, LNG_LO);
		send_request(REQ_QUERY, 0, -1);
		send_request(REQ_QUERY, 0, 1);
		send_request(REQ_QUERY, LAT_HI, LNG_HI);
		send_request(REQ_QUERY, LAT_LO, LNG_HI);
		send_request(REQ_QUERY, LAT_HI, 0);
		send_request(REQ_CLEAR, 0, 0);
	endtask

	// One well-formed sequence: usually a clear, then n vertices on a coarse
	// grid so equal latitudes and longitudes are common, then queries aimed at
	// corners, edge midpoints, points one step off an edge and grid points.
	task automatic polygon_round(input int n, input bit keep_old);
		longint step, clat, clng, lat, lng, off_lat, off_lng;
		int     queries, pick, i, j;
		if (!keep_old) begin
			send_request(REQ_CLEAR, longint'($urandom), longint'($urandom));
			shape_lat.delete();
			shape_lng.delete();
		end
		case ($urandom_range(0, 6))
			0: step = 1;
			1: step = 2;
			2: step = 7;
			3: step = 1000;
			4: step = 65536;
			5: step = longint'(1) <<< 22;
			default: step = $urandom_range(1, 1 << 24);
		endcase
		case ($urandom_range(0, 3))
			0: begin clat = 0; clng = 0; end
			1: begin clat = wrap_lat(longint'($urandom)); clng = wrap_lng(longint'($urandom)); end
			2: begin clat = LAT_HI - 4 * step; clng = LNG_HI - 4 * step; end
			default: begin clat = LAT_LO + 4 * step; clng = LNG_LO + 4 * step; end
		endcase
		for (int k = 0; k < n; k++) begin
			lat = wrap_lat(clat + step * (longint'($urandom_range(0, 8)) - 4));
			lng = wrap_lng(clng + step * (longint'($urandom_range(0, 8)) - 4));
			send_request(REQ_APPEND, lat, lng);
			shape_lat.push_back(lat);
			shape_lng.push_back(lng);
		end
		queries = $urandom_range(2, 10);
		for (int q = 0; q < queries; q++) begin
			pick = $urandom_range(0, 5);
			if (shape_lat.size() == 0 && pick < 3)
				pick = 3;
			i = (shape_lat.size() == 0) ? 0 : $urandom_range(0, shape_lat.size() - 1);
			j = (i + 1 < shape_lat.size()) ? i + 1 : 0;
			off_lat = longint'($urandom_range(0, 4)) - 2;
			off_lng = longint'($urandom_range(0, 4)) - 2;
			case (pick)
				0: begin lat = shape_lat[i]; lng = shape_lng[i]; end
				1: begin
					lat = (shape_lat[i] + shape_lat[j]) >>> 1;
					lng = (shape_lng[i] + shape_lng[j]) >>> 1;
				end
				2: begin
					lat = ((shape_lat[i] + shape_lat[j]) >>> 1) + off_lat / 2;
					lng = ((shape_lng[i] + shape_lng[j]) >>> 1) + off_lng / 2;
				end
				3: begin
					lat = clat + step * (longint'($urandom_range(0, 8)) - 4);
					lng = clng + step * (longint'($urandom_range(0, 8)) - 4);
				end
				4: begin
					lat = clat + step * (longint'($urandom_range(0, 8)) - 4) + off_lat;
					lng = clng + step * (longint'($urandom_range(0, 8)) - 4) + off_lng;
				end
				default: begin lat = longint'($urandom); lng = longint'($urandom); end
			endcase
			send_request(REQ_QUERY, lat, lng);
		end
	endtask

	task automatic run_random();
		bit              held = 1'b0;
		bit              paused = 1'b0;
		int              roll, n;
		logic [REQ_W-1:0] kind;
		// start by overfilling the store so the full-store refusal shows up early
		polygon_round(STORE_DEPTH + 2, 1'b0);
		while (sent_items < ITEM_GOAL) begin
			// keep offering while the receiver sits on a full output
			if (!held && sent_items > 500) begin
				hold_output = 1'b1;
				held = 1'b1;
			end
			// let the block run dry once before going on
			if (!paused && sent_items > 900) begin
				wait_for_answers();
				paused = 1'b1;
			end
			calm = (sent_items > 1100 && sent_items < 1350);
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					n = $urandom_range(3, 10);
				else if (roll < 92)
					n = $urandom_range(0, 2);
				else if (roll < 97)
					n = $urandom_range(11, 40);
				else
					n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
				polygon_round(n, $urandom_range(0, 9) == 0);
			end else begin
				// noise: any request code with full-width coordinates
				repeat ($urandom_range(1, 5)) begin
					kind = REQ_W'($urandom_range(0, 3));
					send_request(kind, longint'($urandom), longint'($urandom));
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int leftover;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_for_answers();
		// give a late or extra answer time to show up
		repeat (TAIL_CYCLES) @(posedge clk);
		leftover = board.pending_answers.size();
		$display("Run covered %0d queries (%0d inside, %0d on an edge), %0d appends (%0d refused),",
			board.n_queries, board.n_inside, board.n_on_edge, board.n_appends, board.n_rejected);
		$display("%0d clears and %0d ignored codes; %0d results checked, %0d wrong, %0d extra, %0d missing",
			board.n_clears, board.n_ignored, board.n_checked, board.mismatches, board.strays,
			leftover);
		if (board.mismatches == 0 && board.strays == 0 && leftover == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* point_in_polygon_test.f */
hdl/pip_pkg.sv
hdl/pip_ram.sv
hdl/pip_mul.sv
hdl/point_in_polygon_test.sv
dv/point_in_polygon_test_test.sv
